// ----- hdl/polygon_area_centroid_defines.svh -----
// Assertion macros for the polygon area and centroid block.
`ifndef POLYGON_AREA_CENTROID_DEFINES_SVH
`define POLYGON_AREA_CENTROID_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PAC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PAC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- hdl/pac_pkg.sv -----
// Shared types and constants for the polygon area and centroid block.
`timescale 1ns / 1ps
`default_nettype none
package pac_pkg;

    localparam int PAC_MAX_POINTS = 1024;

    localparam int COORD_W = 16;
    localparam int PROD_W  = 50;   // 17 x 33 signed product
    localparam int CROSS_W = 44;
    localparam int MOM_W   = 62;
    localparam int AREA_W  = 43;
    localparam int C_W     = 33;   // one edge cross product
    localparam int DEN_W   = 46;   // magnitude of 3 * cross_sum
    localparam int REM_W   = 63;
    localparam int QUO_W   = 17;
    localparam int QCNT_W  = 5;

    // Edge operations on the shared multiplier path
    localparam logic [2:0] EOP_NONE = 3'd0;
    localparam logic [2:0] EOP_P1   = 3'd1;
    localparam logic [2:0] EOP_P2   = 3'd2;
    localparam logic [2:0] EOP_CSUB = 3'd3;
    localparam logic [2:0] EOP_MX   = 3'd4;
    localparam logic [2:0] EOP_MY   = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic                      last_point;
    } vertex_beat_t;

    typedef struct packed {
        logic signed [AREA_W-1:0]  area;
        logic signed [COORD_W-1:0] centroid_x;
        logic signed [COORD_W-1:0] centroid_y;
        logic                      degenerate;
    } result_beat_t;

    typedef struct packed {
        logic       take;
        logic       close;
        logic [2:0] edge_op;
        logic       den_abs;
        logic       den_mul;
        logic       div_start;
        logic       div_y;
        logic       cx_load;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic started;
        logic drop;
        logic in_last;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ----- hdl/pac_div.sv -----
// Restoring divider for the centroid: rounded, saturated 16-bit quotient.
`timescale 1ns / 1ps
`default_nettype none
module pac_div
    import pac_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [MOM_W-1:0]  num,
    input  wire logic        [DEN_W-1:0]  dmag,
    input  wire logic                     dneg,
    output logic                          done,
    output logic signed [COORD_W-1:0]     quo
);

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_ABS  = 3'd1;
    localparam logic [2:0] D_RND  = 3'd2;
    localparam logic [2:0] D_OVF  = 3'd3;
    localparam logic [2:0] D_ITER = 3'd4;
    localparam logic [2:0] D_FIN  = 3'd5;

    localparam logic [QUO_W-1:0] POS_LIM = QUO_W'(32767);
    localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(32768);

    logic [2:0]              state_reg;
    logic                    done_reg;
    logic signed [MOM_W-1:0] num_reg;
    logic                    neg_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [REM_W-1:0]        dsh_reg;
    logic [QUO_W-1:0]        q_reg;
    logic                    ovf_reg;
    logic [QCNT_W-1:0]       cnt_reg;
    logic signed [COORD_W-1:0] quo_reg;

    logic [REM_W-1:0] num_ext;
    logic             fits;

    assign num_ext = {num_reg[MOM_W-1], num_reg};
    assign fits    = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == D_FIN);
            case (state_reg)
                D_IDLE:  if (start) state_reg <= D_ABS;
                D_ABS:   state_reg <= D_RND;
                D_RND:   state_reg <= D_OVF;
                D_OVF:   state_reg <= D_ITER;
                D_ITER:  if (cnt_reg == '0) state_reg <= D_FIN;
                D_FIN:   state_reg <= D_IDLE;
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    num_reg <= num;
                    neg_reg <= num[MOM_W-1] ^ dneg;
                end
            end
            D_ABS:
            begin
                rem_reg <= num_reg[MOM_W-1] ? (REM_W'(0) - num_ext) : num_ext;
            end
            D_RND:
            begin
                // round to nearest: add half the divisor
                rem_reg <= rem_reg + {{(REM_W-DEN_W+1){1'b0}}, dmag[DEN_W-1:1]};
                dsh_reg <= {dmag, {(REM_W-DEN_W){1'b0}}};
            end
            D_OVF:
            begin
                ovf_reg <= fits;
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= QCNT_W'(QUO_W - 1);
                q_reg   <= '0;
            end
            D_ITER:
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg   <= {q_reg[QUO_W-2:0], fits};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            D_FIN:
            begin
                if (neg_reg)
                begin
                    quo_reg <= (ovf_reg || q_reg > NEG_LIM) ? 16'sh8000
                             : COORD_W'(16'd0 - q_reg[COORD_W-1:0]);
                end
                else
                begin
                    quo_reg <= (ovf_reg || q_reg > POS_LIM) ? 16'sh7fff
                             : q_reg[COORD_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

// ----- hdl/pac_dp.sv -----
// Datapath: vertex registers, shared multiplier, running sums, divider, output register.
`timescale 1ns / 1ps
`default_nettype none
module pac_dp
    import pac_pkg::*;
#(
    parameter int MAX_POINTS = PAC_MAX_POINTS
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire dp_cmd_t      cmd,
    output dp_status_t        status,
    input  wire vertex_beat_t vertex,
    output logic              result_valid,
    input  wire logic         result_stall,
    output result_beat_t      result
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic                 started_reg;
    logic [CNT_W-1:0]     count_reg;
    logic signed [CROSS_W-1:0] cross_reg;
    logic signed [MOM_W-1:0]   mx_sum_reg;
    logic signed [MOM_W-1:0]   my_sum_reg;
    logic                 my_pend_reg;
    logic                 out_valid_reg;
    result_beat_t         out_reg;

    logic signed [COORD_W-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_W-1:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg;
    logic signed [C_W-1:0]     c_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [CROSS_W-1:0]        cabs_reg;
    logic                      cneg_reg;
    logic [DEN_W-1:0]          dmag_reg;
    logic signed [COORD_W-1:0] cx_reg;

    logic signed [COORD_W:0]   mul_a;
    logic signed [C_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic                      mul_en;
    logic                      drop;
    logic                      out_free;
    logic                      degen;
    logic                      div_done;
    logic signed [COORD_W-1:0] div_quo;

    assign drop     = !vertex.last_point && started_reg
                      && (count_reg >= CNT_W'(MAX_POINTS - 1));
    assign out_free = !out_valid_reg || !result_stall;
    assign degen    = (cross_reg[CROSS_W-1:1] == '0);

    always_comb
    begin
        mul_en = 1'b1;
        case (cmd.edge_op)
            EOP_P1:
            begin
                mul_a = {e0x_reg[COORD_W-1], e0x_reg};
                mul_b = C_W'(e1y_reg);
            end
            EOP_P2:
            begin
                mul_a = {e1x_reg[COORD_W-1], e1x_reg};
                mul_b = C_W'(e0y_reg);
            end
            EOP_MX:
            begin
                mul_a = {e0x_reg[COORD_W-1], e0x_reg} + {e1x_reg[COORD_W-1], e1x_reg};
                mul_b = c_reg;
            end
            EOP_MY:
            begin
                mul_a = {e0y_reg[COORD_W-1], e0y_reg} + {e1y_reg[COORD_W-1], e1y_reg};
                mul_b = c_reg;
            end
            default:
            begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Control state and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            count_reg     <= '0;
            cross_reg     <= '0;
            mx_sum_reg    <= '0;
            my_sum_reg    <= '0;
            my_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            my_pend_reg <= (cmd.edge_op == EOP_MY);
            if (cmd.take && !drop)
            begin
                started_reg <= 1'b1;
                count_reg   <= started_reg ? CNT_W'(count_reg + 1'b1) : CNT_W'(1);
            end
            if (cmd.edge_op == EOP_MX)
            begin
                cross_reg <= cross_reg + CROSS_W'(c_reg);
            end
            if (cmd.edge_op == EOP_MY)
            begin
                mx_sum_reg <= mx_sum_reg + MOM_W'(prod_reg);
            end
            if (my_pend_reg)
            begin
                my_sum_reg <= my_sum_reg + MOM_W'(prod_reg);
            end
            if (cmd.out_load)
            begin
                // result taken from the sums; start the next polygon clean
                started_reg   <= 1'b0;
                count_reg     <= '0;
                cross_reg     <= '0;
                mx_sum_reg    <= '0;
                my_sum_reg    <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take && !drop)
        begin
            prev_x_reg <= vertex.x_coord;
            prev_y_reg <= vertex.y_coord;
            if (!started_reg)
            begin
                first_x_reg <= vertex.x_coord;
                first_y_reg <= vertex.y_coord;
            end
            else
            begin
                e0x_reg <= prev_x_reg;
                e0y_reg <= prev_y_reg;
                e1x_reg <= vertex.x_coord;
                e1y_reg <= vertex.y_coord;
            end
        end
        if (cmd.close)
        begin
            e0x_reg <= prev_x_reg;
            e0y_reg <= prev_y_reg;
            e1x_reg <= first_x_reg;
            e1y_reg <= first_y_reg;
        end
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.edge_op == EOP_P2)
        begin
            c_reg <= prod_reg[C_W-1:0];
        end
        else if (cmd.edge_op == EOP_CSUB)
        begin
            c_reg <= c_reg - prod_reg[C_W-1:0];
        end
        if (cmd.den_abs)
        begin
            cneg_reg <= cross_reg[CROSS_W-1];
            cabs_reg <= cross_reg[CROSS_W-1] ? (CROSS_W'(0) - cross_reg) : cross_reg;
        end
        if (cmd.den_mul)
        begin
            dmag_reg <= {1'b0, cabs_reg, 1'b0} + {2'b00, cabs_reg};
        end
        if (cmd.cx_load)
        begin
            cx_reg <= div_quo;
        end
        if (cmd.out_load)
        begin
            out_reg.area       <= cross_reg[CROSS_W-1:1];
            out_reg.degenerate <= degen;
            out_reg.centroid_x <= degen ? '0 : cx_reg;
            out_reg.centroid_y <= degen ? '0 : div_quo;
        end
    end

    pac_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (cmd.div_y ? my_sum_reg : mx_sum_reg),
        .dmag  (dmag_reg),
        .dneg  (cneg_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign status.started  = started_reg;
    assign status.drop     = drop;
    assign status.in_last  = vertex.last_point;
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ----- hdl/pac_ctrl.sv -----
// Controller: sequences edge passes, the closing edge, the two divides and the result load.
`timescale 1ns / 1ps
`default_nettype none
module pac_ctrl
    import pac_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       vertex_valid,
    output logic            vertex_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLOSE = 4'd1;
    localparam logic [3:0] S_P1    = 4'd2;
    localparam logic [3:0] S_P2    = 4'd3;
    localparam logic [3:0] S_CSUB  = 4'd4;
    localparam logic [3:0] S_MX    = 4'd5;
    localparam logic [3:0] S_MY    = 4'd6;
    localparam logic [3:0] S_DABS  = 4'd7;
    localparam logic [3:0] S_DMUL  = 4'd8;
    localparam logic [3:0] S_DXGO  = 4'd9;
    localparam logic [3:0] S_DXWT  = 4'd10;
    localparam logic [3:0] S_DYGO  = 4'd11;
    localparam logic [3:0] S_DYWT  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       pend_last_reg, pend_last_next;
    logic       is_close_reg, is_close_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_last_reg <= 1'b0;
            is_close_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_last_reg <= pend_last_next;
            is_close_reg  <= is_close_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.edge_op    = EOP_NONE;
        state_next     = state_reg;
        pend_last_next = pend_last_reg;
        is_close_next  = is_close_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (vertex_valid)
                begin
                    cmd.take = 1'b1;
                    if (!status.drop)
                    begin
                        if (!status.started)
                        begin
                            if (status.in_last)
                            begin
                                state_next = S_CLOSE;
                            end
                        end
                        else
                        begin
                            pend_last_next = status.in_last;
                            state_next     = S_P1;
                        end
                    end
                end
            end
            S_CLOSE:
            begin
                cmd.close     = 1'b1;
                is_close_next = 1'b1;
                state_next    = S_P1;
            end
            S_P1:
            begin
                cmd.edge_op = EOP_P1;
                state_next  = S_P2;
            end
            S_P2:
            begin
                cmd.edge_op = EOP_P2;
                state_next  = S_CSUB;
            end
            S_CSUB:
            begin
                cmd.edge_op = EOP_CSUB;
                state_next  = S_MX;
            end
            S_MX:
            begin
                cmd.edge_op = EOP_MX;
                state_next  = S_MY;
            end
            S_MY:
            begin
                cmd.edge_op = EOP_MY;
                if (is_close_reg)
                begin
                    is_close_next = 1'b0;
                    state_next    = S_DABS;
                end
                else if (pend_last_reg)
                begin
                    pend_last_next = 1'b0;
                    state_next     = S_CLOSE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DABS:
            begin
                cmd.den_abs = 1'b1;
                state_next  = S_DMUL;
            end
            S_DMUL:
            begin
                cmd.den_mul = 1'b1;
                state_next  = S_DXGO;
            end
            S_DXGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DXWT;
            end
            S_DXWT:
            begin
                if (status.div_done)
                begin
                    cmd.cx_load = 1'b1;
                    state_next  = S_DYGO;
                end
            end
            S_DYGO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_y     = 1'b1;
                state_next    = S_DYWT;
            end
            S_DYWT:
            begin
                if (status.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register can take the beat
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign vertex_stall = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// ----- hdl/polygon_area_centroid.sv -----
// Top level of the polygon area and centroid block.
//
//  channel  | signals                               | beat
//  ---------+---------------------------------------+-------------------------------
//  vertex   | vertex_valid, vertex_stall, vertex    | x, y, last-vertex flag
//  result   | result_valid, result_stall, result    | area, centroid x/y, degenerate
//
// A later vertex is accepted and then runs the edge passes P1, P2, CSUB, MX and MY, all but
// CSUB through the shared 17 x 33 multiplier; the first vertex is only stored, and a vertex
// dropped past the limit is discarded. The flagged vertex adds the closing edge, the divisor,
// two divides on one divider and the output load. The result sits in an output register;
// a stalled result holds the block only when the next result is ready. rst_n clears
// control state at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module polygon_area_centroid
    import pac_pkg::*;
#(
    parameter int MAX_POINTS = PAC_MAX_POINTS
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         vertex_valid,
    output logic              vertex_stall,
    input  wire vertex_beat_t vertex,
    output logic              result_valid,
    input  wire logic         result_stall,
    output result_beat_t      result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    pac_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .status       (status),
        .cmd          (cmd)
    );

    pac_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire

// ----- hdl/pac_chk.sv -----
// Port-level checker for the polygon area and centroid block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "polygon_area_centroid_defines.svh"
module pac_chk
    import pac_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         vertex_valid,
    input wire logic         vertex_stall,
    input wire vertex_beat_t vertex,
    input wire logic         result_valid,
    input wire logic         result_stall,
    input wire result_beat_t result
);

    `PAC_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
    `PAC_ASSERT_IMP(a_degen_area, result_valid, result.degenerate == (result.area == '0))
    `PAC_ASSERT_IMP(a_degen_zero, result_valid && result.degenerate, result.centroid_x == '0 && result.centroid_y == '0)
    `PAC_ASSERT_NXT(a_no_early_result, vertex_valid && !vertex_stall, !$rose(result_valid))

endmodule

bind polygon_area_centroid pac_chk u_pac_chk (.*);
`default_nettype wire
